### src/ple_pkg.sv
// Package for the positional list engine: command and result payload types,
// mode and status codes, sequencer operation codes. No dependencies.
`default_nettype none
package ple_pkg;

	localparam int MAX_RESULTS = 16;

	localparam logic [2:0] MODE_INS_FRONT = 3'd0;
	localparam logic [2:0] MODE_INS_END   = 3'd1;
	localparam logic [2:0] MODE_INS_AT    = 3'd2;
	localparam logic [2:0] MODE_DEL_FRONT = 3'd3;
	localparam logic [2:0] MODE_DEL_END   = 3'd4;
	localparam logic [2:0] MODE_DEL_AT    = 3'd5;
	localparam logic [2:0] MODE_DUMP      = 3'd6;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_BOUNDS = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INS,
		OP_DEL,
		OP_DUMP
	} op_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] value;
		logic [4:0]         position;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] item_value;
		logic [3:0]         item_index;
		logic               last;
	} res_t;

	// decoded plan for one command
	typedef struct packed {
		op_t        op;
		logic [1:0] status;
	} plan_t;

endpackage
`default_nettype wire

### src/positional_list_engine.sv
// Positional list engine top: sequencer moving entries one at a time through the entry RAM.
// Depends on ple_pkg, ple_dec, ple_ram. Rejected commands and mode 7: busy stays low,
// result in the cycle after the transfer. Insert and delete move each shifted entry by a
// RAM read, then a write one slot over; dump reads each entry, then sends its result.
// busy drops with the final result and the receiver cannot stall. Async reset empties
// the list; RAM is not cleared.
`default_nettype none
module positional_list_engine #(
	parameter int CAPACITY = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire ple_pkg::cmd_t cmd,
	output logic               busy,
	output logic               strobe,
	output ple_pkg::res_t      result
);
	import ple_pkg::*;

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_WR,
		S_DEL_RD,
		S_DEL_WR,
		S_DMP_RD,
		S_DMP_OUT
	} state_t;

	state_t             state_q;
	logic [LW-1:0]      len_q;
	logic [LW-1:0]      idx_q;
	logic [LW-1:0]      pos_q;
	logic [LW-1:0]      cnt_q;
	logic signed [31:0] val_q;

	plan_t              plan;
	logic [LW-1:0]      dec_pos;
	logic [LW-1:0]      dec_cnt;
	logic [LW-1:0]      idx_dn;
	logic [LW-1:0]      idx_up;
	logic               at_pos;
	logic               del_end;
	logic               dmp_last;

	logic               we;
	logic [AW-1:0]      waddr;
	logic [31:0]        wdata;
	logic [AW-1:0]      raddr;
	logic [31:0]        rdata;

	ple_dec #(.CAPACITY(CAPACITY)) u_dec (
		.mode     (cmd.mode),
		.position (cmd.position),
		.len      (len_q),
		.plan     (plan),
		.pos      (dec_pos),
		.cnt      (dec_cnt)
	);

	ple_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign idx_dn   = idx_q - 1'b1;
	assign idx_up   = idx_q + 1'b1;
	assign at_pos   = (idx_q == pos_q);
	assign del_end  = (({1'b0, idx_q} + 1'b1) >= {1'b0, len_q});
	assign dmp_last = (({1'b0, idx_q} + 1'b1) == {1'b0, cnt_q});
	assign busy     = (state_q != S_IDLE);

	always_comb begin
		raddr = idx_q[AW-1:0];
		case (state_q)
			S_INS_RD: raddr = idx_dn[AW-1:0];
			S_DEL_RD: raddr = idx_up[AW-1:0];
			default:  raddr = idx_q[AW-1:0];
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		case (state_q)
			S_INS_RD: begin
				if (at_pos) begin
					we    = 1'b1;
					wdata = val_q;
				end
			end
			S_INS_WR, S_DEL_WR: we = 1'b1;
			default:  we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			strobe  <= 1'b0;
			idx_q   <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			val_q   <= '0;
			result  <= '0;
		end else begin
			strobe <= 1'b0;
			result <= '0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						val_q <= cmd.value;
						pos_q <= dec_pos;
						cnt_q <= dec_cnt;
						case (plan.op)
							OP_INS: begin
								idx_q   <= len_q;
								state_q <= S_INS_RD;
							end
							OP_DEL: begin
								idx_q   <= dec_pos;
								state_q <= S_DEL_RD;
							end
							OP_DUMP: begin
								idx_q   <= '0;
								state_q <= S_DMP_RD;
							end
							default: begin
								strobe        <= 1'b1;
								result.status <= plan.status;
								result.last   <= 1'b1;
							end
						endcase
					end
				end
				S_INS_RD: begin
					if (at_pos) begin
						len_q         <= len_q + 1'b1;
						strobe        <= 1'b1;
						result.status <= ST_OK;
						result.last   <= 1'b1;
						state_q       <= S_IDLE;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					idx_q   <= idx_dn;
					state_q <= S_INS_RD;
				end
				S_DEL_RD: begin
					if (del_end) begin
						len_q         <= len_q - 1'b1;
						strobe        <= 1'b1;
						result.status <= ST_OK;
						result.last   <= 1'b1;
						state_q       <= S_IDLE;
					end else begin
						state_q <= S_DEL_WR;
					end
				end
				S_DEL_WR: begin
					idx_q   <= idx_up;
					state_q <= S_DEL_RD;
				end
				S_DMP_RD: begin
					state_q <= S_DMP_OUT;
				end
				S_DMP_OUT: begin
					strobe            <= 1'b1;
					result.status     <= ST_OK;
					result.item_value <= rdata;
					result.item_index <= 4'(idx_q);
					result.last       <= dmp_last;
					idx_q             <= idx_up;
					state_q           <= dmp_last ? S_IDLE : S_DMP_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(CAPACITY))
		else $error("list length above capacity");

	a_start_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || strobe)
		else $error("transferred command neither running nor answered");

	a_partial_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("non-final dump result while idle");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != ST_OK |-> result.last)
		else $error("error status not marked last");

endmodule
`default_nettype wire

### src/ple_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### src/ple_dec.sv
// Command decoder: bound, full and empty checks against the current length,
// target position and dump count. Depends on ple_pkg.
`default_nettype none
module ple_dec #(
	parameter int CAPACITY = 16
) (
	input  wire logic [2:0]                     mode,
	input  wire logic [4:0]                     position,
	input  wire logic [$clog2(CAPACITY+1)-1:0]  len,
	output ple_pkg::plan_t                      plan,
	output logic      [$clog2(CAPACITY+1)-1:0]  pos,
	output logic      [$clog2(CAPACITY+1)-1:0]  cnt
);
	import ple_pkg::*;

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > 5) ? LW : 5;

	logic [CW-1:0] lenw;
	logic [CW-1:0] posw;
	logic [CW-1:0] p;
	logic [CW-1:0] cntw;

	assign lenw = CW'(len);
	assign posw = CW'(position);

	always_comb begin
		p = '0;
		plan.op = OP_NONE;
		plan.status = ST_OK;
		case (mode)
			MODE_INS_FRONT, MODE_INS_END, MODE_INS_AT: begin
				if (mode == MODE_INS_END) begin
					p = lenw;
				end else if (mode == MODE_INS_AT) begin
					p = posw;
				end
				// bound check wins over full check
				if (p > lenw) begin
					plan.status = ST_BOUNDS;
				end else if (lenw >= CW'(CAPACITY)) begin
					plan.status = ST_FULL;
				end else begin
					plan.op = OP_INS;
				end
			end
			MODE_DEL_FRONT, MODE_DEL_END, MODE_DEL_AT: begin
				if (mode == MODE_DEL_END) begin
					p = lenw - 1'b1;
				end else if (mode == MODE_DEL_AT) begin
					p = posw;
				end
				if (lenw == '0) begin
					plan.status = ST_EMPTY;
				end else if (p >= lenw) begin
					plan.status = ST_BOUNDS;
				end else begin
					plan.op = OP_DEL;
				end
			end
			MODE_DUMP: begin
				if (lenw == '0) begin
					plan.status = ST_EMPTY;
				end else begin
					plan.op = OP_DUMP;
				end
			end
			default: begin
				plan.op = OP_NONE;
			end
		endcase
	end

	assign cntw = (lenw < CW'(MAX_RESULTS)) ? lenw : CW'(MAX_RESULTS);
	assign pos = LW'(p);
	assign cnt = LW'(cntw);

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for positional_list_engine: directed table, then random commands.
// Expected results come from a list model kept in step with accepted transfers.
// Depends on ple_pkg and the engine RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ple_pkg::*;

	localparam int CAPACITY = 16;
	localparam int WATCHDOG = 1000;
	localparam int RANDOM_ITEMS = 450;
	localparam logic [2:0] MODE_SPARE = 3'd7;

	typedef struct {
		logic [2:0]  mode;
		logic [31:0] value;
		logic [4:0]  position;
		int          reps;
		bit          known;
		logic [1:0]  status;
	} step_t;

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic strobe;
	res_t result;

	logic signed [31:0] shadow_list[$];
	res_t pending_results[$];
	int mismatches = 0;
	int stall_cycles = 0;
	bit no_idle = 0;

	// known status typed in where it follows at a glance; the rest goes to the list model
	step_t directed[25] = '{
		'{MODE_DUMP,      32'h0,         5'd0,  1,  1, ST_EMPTY},
		'{MODE_DEL_FRONT, 32'h0,         5'd0,  1,  1, ST_EMPTY},
		'{MODE_DEL_END,   32'h0,         5'd0,  1,  1, ST_EMPTY},
		'{MODE_DEL_AT,    32'h0,         5'd31, 1,  1, ST_EMPTY},
		'{MODE_INS_AT,    32'h5,         5'd1,  1,  1, ST_BOUNDS},
		'{MODE_INS_FRONT, 32'h7fff_ffff, 5'd0,  1,  1, ST_OK},
		'{MODE_INS_END,   32'h8000_0000, 5'd0,  1,  1, ST_OK},
		'{MODE_INS_AT,    32'hffff_ffff, 5'd1,  1,  1, ST_OK},
		'{MODE_INS_AT,    32'h0,         5'd3,  1,  1, ST_OK},
		'{MODE_DEL_AT,    32'h0,         5'd4,  1,  1, ST_BOUNDS},
		'{MODE_DUMP,      32'h0,         5'd0,  1,  0, ST_OK},
		'{MODE_SPARE,     32'h5555_aaaa, 5'd21, 1,  1, ST_OK},
		'{MODE_INS_AT,    32'h7,         5'd31, 1,  1, ST_BOUNDS},
		'{MODE_INS_AT,    32'h1234_5678, 5'd2,  12, 0, ST_OK},
		'{MODE_INS_END,   32'h1,         5'd0,  1,  1, ST_FULL},
		'{MODE_INS_FRONT, 32'h2,         5'd0,  1,  1, ST_FULL},
		'{MODE_INS_AT,    32'h3,         5'd17, 1,  1, ST_BOUNDS},
		'{MODE_INS_AT,    32'h4,         5'd16, 1,  1, ST_FULL},
		'{MODE_DUMP,      32'h0,         5'd0,  1,  0, ST_OK},
		'{MODE_DEL_AT,    32'h0,         5'd16, 1,  1, ST_BOUNDS},
		'{MODE_DEL_AT,    32'h0,         5'd15, 1,  1, ST_OK},
		'{MODE_DEL_END,   32'h0,         5'd0,  1,  1, ST_OK},
		'{MODE_DEL_FRONT, 32'h0,         5'd0,  1,  1, ST_OK},
		'{MODE_DEL_AT,    32'h0,         5'd5,  1,  1, ST_OK},
		'{MODE_DUMP,      32'h0,         5'd0,  1,  0, ST_OK}
	};

	positional_list_engine #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.strobe(strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// update the list model for one accepted command and queue the results it causes
	function automatic void apply_command(cmd_t c, bit known, logic [1:0] known_status);
		res_t outs[$];
		res_t r;
		int len;
		int pos;
		int n;
		logic [1:0] st;
		len = shadow_list.size();
		st = ST_OK;
		case (c.mode)
			MODE_INS_FRONT, MODE_INS_END, MODE_INS_AT: begin
				pos = (c.mode == MODE_INS_FRONT) ? 0 :
				      (c.mode == MODE_INS_END) ? len : int'(c.position);
				// bound check wins over full
				if (pos > len)
					st = ST_BOUNDS;
				else if (len >= CAPACITY)
					st = ST_FULL;
				else
					shadow_list.insert(pos, c.value);
			end
			MODE_DEL_FRONT, MODE_DEL_END, MODE_DEL_AT: begin
				pos = (c.mode == MODE_DEL_FRONT) ? 0 :
				      (c.mode == MODE_DEL_END) ? len - 1 : int'(c.position);
				if (len == 0)
					st = ST_EMPTY;
				else if (pos >= len)
					st = ST_BOUNDS;
				else
					shadow_list.delete(pos);
			end
			MODE_DUMP: begin
				if (len == 0)
					st = ST_EMPTY;
				n = (len < MAX_RESULTS) ? len : MAX_RESULTS;
				for (int i = 0; i < n; i++) begin
					r.status = ST_OK;
					r.item_value = shadow_list[i];
					r.item_index = 4'(i);
					r.last = (i + 1 == n);
					outs.push_back(r);
				end
			end
			default: ;
		endcase
		if (outs.size() == 0) begin
			r.status = st;
			r.item_value = '0;
			r.item_index = '0;
			r.last = 1'b1;
			outs.push_back(r);
		end
		if (known) begin
			r.status = known_status;
			r.item_value = '0;
			r.item_index = '0;
			r.last = 1'b1;
			pending_results.push_back(r);
		end else begin
			foreach (outs[i])
				pending_results.push_back(outs[i]);
		end
	endfunction

	// hold start until the transfer edge; the model is updated at that edge
	task automatic issue(cmd_t c, bit known, logic [1:0] known_status);
		if (!no_idle && $urandom_range(0, 99) < 32) begin
			start <= 1'b0;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(7, 40)) @(posedge clk);
			else
				repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (busy);
		apply_command(c, known, known_status);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	// steer the list length toward a target so it sweeps from empty to full
	function automatic cmd_t pick_command(int target_len);
		cmd_t c;
		int len;
		int r;
		bit grow;
		len = shadow_list.size();
		r = $urandom_range(0, 99);
		grow = (len < target_len) || (len == target_len && $urandom_range(0, 1));
		if ($urandom_range(0, 9) == 0)
			grow = !grow;
		if (r < 3)
			c.mode = MODE_SPARE;
		else if (r < 13)
			c.mode = MODE_DUMP;
		else if (grow)
			c.mode = 3'($urandom_range(MODE_INS_FRONT, MODE_INS_AT));
		else
			c.mode = 3'($urandom_range(MODE_DEL_FRONT, MODE_DEL_AT));
		c.value = pick_value();
		c.position = 5'($urandom_range(0, 31));
		if ($urandom_range(0, 99) < 85) begin
			if (c.mode == MODE_INS_AT)
				c.position = 5'($urandom_range(0, len));
			else if (c.mode == MODE_DEL_AT)
				c.position = 5'($urandom_range(0, (len > 0) ? len - 1 : 0));
		end
		return c;
	endfunction

	initial begin
		cmd_t c;
		int target_len;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		target_len = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			for (int k = 0; k < directed[i].reps; k++) begin
				c.mode = directed[i].mode;
				c.value = directed[i].value + k;
				c.position = directed[i].position;
				issue(c, directed[i].known, directed[i].status);
			end
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				if ($urandom_range(0, 2) == 0)
					target_len = $urandom_range(0, 1) ? CAPACITY : 0;
				else
					target_len = $urandom_range(0, CAPACITY);
			end
			no_idle = (n >= 150 && n < 250);
			// sender waits for the engine to drain
			if (n == 100 || $urandom_range(0, 49) == 0) begin
				start <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			issue(pick_command(target_len), 1'b0, ST_OK);
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("** positional_list_engine: PASSED **");
		else
			$display("** positional_list_engine: FAILED **");
		$finish;
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %p", $time, result);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(result.status));
				check_field("item_value", want.item_value, result.item_value);
				check_field("item_index", 32'(want.item_index), 32'(result.item_index));
				check_field("last", 32'(want.last), 32'(result.last));
			end
		end
	end

	// cycles with neither a command transfer nor a result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == WATCHDOG) begin
			$display("** positional_list_engine: FAILED **");
			$finish;
		end
	end

endmodule
